// ----- src/mvcf_pkg.sv -----
// ----------------------------------------------------------------------------
// mvcf_pkg
// Shared types and constants of the memory value candidate filter: geometry
// of the paged RAM, mark row packing, pass codes and the queue entry.
// ----------------------------------------------------------------------------
package mvcf_pkg;

  localparam int PAGE_COUNT = 16;
  localparam int PAGE_BYTES = 8192;

  localparam int PAGE_W   = 4;
  localparam int OFFSET_W = 13;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 18;

  localparam int STORE_DEPTH = PAGE_COUNT * PAGE_BYTES;
  localparam int SNAP_AW     = $clog2(STORE_DEPTH);

  localparam int MARK_ROW_W = 32;
  localparam int BIT_W      = $clog2(MARK_ROW_W);
  localparam int MARK_ROWS  = (STORE_DEPTH + MARK_ROW_W - 1) / MARK_ROW_W;
  localparam int MARK_AW    = $clog2(MARK_ROWS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_EQUAL     = 2'd1,
    OP_INCREASED = 2'd2,
    OP_DECREASED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic               in_range;
    logic [SNAP_AW-1:0] snap_addr;
    logic [MARK_AW-1:0] row_addr;
    logic [BIT_W-1:0]   bit_sel;
    logic [BYTE_W-1:0]  mem_byte;
    logic               writable;
    logic               eq_match;
    logic               new_pass;
  } entry_t;

  typedef struct packed {
    logic full;
    logic sweeping;
  } front_ctrl_t;

endpackage

// ----- src/mvcf_in_if.sv -----
// ----------------------------------------------------------------------------
// mvcf_in_if
// Input channel: one RAM byte of one pass per beat.
// ----------------------------------------------------------------------------
interface mvcf_in_if;
  logic                          valid;
  logic                          ready;
  mvcf_pkg::op_e                 op;
  logic [mvcf_pkg::PAGE_W-1:0]   page;
  logic [mvcf_pkg::OFFSET_W-1:0] offset;
  logic [mvcf_pkg::BYTE_W-1:0]   mem_byte;
  logic                          writable;
  logic [mvcf_pkg::BYTE_W-1:0]   search_value;
  logic                          new_pass;

  modport source (
    output valid, op, page, offset, mem_byte, writable, search_value, new_pass,
    input  ready
  );
  modport sink (
    input  valid, op, page, offset, mem_byte, writable, search_value, new_pass,
    output ready
  );
endinterface

// ----- src/mvcf_out_if.sv -----
// ----------------------------------------------------------------------------
// mvcf_out_if
// Result channel: one verdict and the running candidate count per beat.
// ----------------------------------------------------------------------------
interface mvcf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_candidate;
  logic                         dropped;
  logic [mvcf_pkg::COUNT_W-1:0] candidate_count;

  modport source (
    output valid, is_candidate, dropped, candidate_count,
    input  ready
  );
  modport sink (
    input  valid, is_candidate, dropped, candidate_count,
    output ready
  );
endinterface

// ----- src/memory_value_candidate_filter.sv -----
// ----------------------------------------------------------------------------
// memory_value_candidate_filter
// Narrows candidate RAM bytes across clear, equal, increased and decreased
// passes; one result beat per input beat.
// ----------------------------------------------------------------------------
// Each input beat passes the back-end states IDLE and EXEC: IDLE reads the
// snapshot byte and the 32-bit exclusion mark row from their RAMs (registered
// read), EXEC decides and writes both back once the result register is free.
// The back end reads no next beat until this read-modify-write on the
// memories is done. A two-entry queue lets the front accept while the back
// works or the result waits. After reset the 4096 mark RAM rows are swept to
// all excluded, one row a cycle, during which no input beat is accepted.
module memory_value_candidate_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  mvcf_in_if.sink     in_i,
  mvcf_out_if.source  out_o
);

  mvcf_pkg::entry_t      entry, head;
  mvcf_pkg::front_ctrl_t front_ctrl;
  logic                  push, pop, empty, full, sweeping;

  assign front_ctrl.full     = full;
  assign front_ctrl.sweeping = sweeping;

  mvcf_front u_front (
    .in_i    (in_i),
    .ctrl_i  (front_ctrl),
    .push_o  (push),
    .entry_o (entry)
  );

  mvcf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  mvcf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .sweeping_o (sweeping),
    .out_o      (out_o)
  );

endmodule

// ----- src/mvcf_ram.sv -----
// ----------------------------------------------------------------------------
// mvcf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- src/mvcf_front.sv -----
// ----------------------------------------------------------------------------
// mvcf_front
// Accepts input beats, checks the address range, forms the store and mark
// addresses and the equality match, and hands an entry to the queue.
// ----------------------------------------------------------------------------
module mvcf_front (
  mvcf_in_if.sink                 in_i,
  input  mvcf_pkg::front_ctrl_t   ctrl_i,
  output logic                    push_o,
  output mvcf_pkg::entry_t        entry_o
);

  logic [mvcf_pkg::SNAP_AW-1:0] idx;

  assign in_i.ready = !ctrl_i.full && !ctrl_i.sweeping;
  assign push_o     = in_i.valid && in_i.ready;

  assign idx = mvcf_pkg::SNAP_AW'(in_i.page) * mvcf_pkg::SNAP_AW'(mvcf_pkg::PAGE_BYTES)
             + mvcf_pkg::SNAP_AW'(in_i.offset);

  always_comb begin
    entry_o.op        = in_i.op;
    entry_o.in_range  = (32'(in_i.page) < mvcf_pkg::PAGE_COUNT)
                     && (32'(in_i.offset) < mvcf_pkg::PAGE_BYTES);
    entry_o.snap_addr = idx;
    entry_o.row_addr  = idx[mvcf_pkg::SNAP_AW-1:mvcf_pkg::BIT_W];
    entry_o.bit_sel   = idx[mvcf_pkg::BIT_W-1:0];
    entry_o.mem_byte  = in_i.mem_byte;
    entry_o.writable  = in_i.writable;
    entry_o.eq_match  = (in_i.mem_byte == in_i.search_value);
    entry_o.new_pass  = in_i.new_pass;
  end

endmodule

// ----- src/mvcf_fifo.sv -----
// ----------------------------------------------------------------------------
// mvcf_fifo
// Short queue between the front and the back, so each side stalls alone.
// ----------------------------------------------------------------------------
module mvcf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mvcf_pkg::entry_t    entry_i,
  input  logic                pop_i,
  output mvcf_pkg::entry_t    head_o,
  output logic                empty_o,
  output logic                full_o
);

  mvcf_pkg::entry_t            slot_q [mvcf_pkg::QUEUE_DEPTH];
  logic [mvcf_pkg::QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [mvcf_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  localparam logic [mvcf_pkg::QPTR_W-1:0] LastPtr = mvcf_pkg::QPTR_W'(mvcf_pkg::QUEUE_DEPTH - 1);
  localparam logic [mvcf_pkg::QCNT_W-1:0] FullCnt = mvcf_pkg::QCNT_W'(mvcf_pkg::QUEUE_DEPTH);

  assign head_o  = slot_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count beyond depth");

endmodule

// ----- src/mvcf_back.sv -----
// ----------------------------------------------------------------------------
// mvcf_back
// Carries out queued entries: reads the snapshot byte and the mark row,
// decides keep or drop, writes both back, updates the running count and
// loads the result register. Sweeps the mark memory to excluded after reset.
// ----------------------------------------------------------------------------
module mvcf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mvcf_pkg::entry_t      head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  sweeping_o,
  mvcf_out_if.source            out_o
);

  localparam logic [mvcf_pkg::MARK_AW-1:0] LastRow = mvcf_pkg::MARK_AW'(mvcf_pkg::MARK_ROWS - 1);

  mvcf_pkg::back_state_e           state_q, state_d;
  logic [mvcf_pkg::MARK_AW-1:0]    sweep_q, sweep_d;
  logic [mvcf_pkg::COUNT_W-1:0]    count_q, count_d, count_base;
  logic                            out_valid_q, out_valid_d;
  logic                            cand_q, cand_d, drop_q, drop_d;
  mvcf_pkg::entry_t                cur_q;

  logic                            out_free, exec_fire;
  logic [mvcf_pkg::BYTE_W-1:0]     snap_rdata;
  logic [mvcf_pkg::MARK_ROW_W-1:0] mark_rdata, mark_new;
  logic                            excl, keep, new_mark;
  logic                            snap_we, mark_we, exec_mark_we;
  logic [mvcf_pkg::MARK_AW-1:0]    mark_waddr;
  logic [mvcf_pkg::MARK_ROW_W-1:0] mark_wdata;

  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mvcf_pkg::BK_SWEEP: if (sweep_q == LastRow) state_d = mvcf_pkg::BK_IDLE;
      mvcf_pkg::BK_IDLE:  if (!empty_i) state_d = mvcf_pkg::BK_EXEC;
      mvcf_pkg::BK_EXEC:  if (out_free) state_d = mvcf_pkg::BK_IDLE;
      default:            state_d = mvcf_pkg::BK_SWEEP;
    endcase
  end

  // state outputs
  always_comb begin
    sweeping_o = 1'b0;
    pop_o      = 1'b0;
    exec_fire  = 1'b0;
    case (state_q)
      mvcf_pkg::BK_SWEEP: sweeping_o = 1'b1;
      mvcf_pkg::BK_IDLE:  pop_o      = !empty_i;
      mvcf_pkg::BK_EXEC:  exec_fire  = out_free;
      default:            sweeping_o = 1'b1;
    endcase
  end

  assign sweep_d = (state_q == mvcf_pkg::BK_SWEEP) ? sweep_q + 1'b1 : sweep_q;

  // keep or drop decision
  always_comb begin
    excl         = mark_rdata[cur_q.bit_sel];
    keep         = 1'b0;
    new_mark     = excl;
    cand_d       = 1'b0;
    drop_d       = 1'b0;
    snap_we      = 1'b0;
    exec_mark_we = 1'b0;
    count_base   = count_q;
    count_d      = count_q;
    case (cur_q.op)
      mvcf_pkg::OP_EQUAL:     keep = cur_q.eq_match;
      mvcf_pkg::OP_INCREASED: keep = cur_q.mem_byte > snap_rdata;
      mvcf_pkg::OP_DECREASED: keep = cur_q.mem_byte < snap_rdata;
      default:                keep = 1'b0;
    endcase
    if (cur_q.in_range) begin
      if (cur_q.op == mvcf_pkg::OP_CLEAR) begin
        exec_mark_we = 1'b1;
        if (cur_q.new_pass) begin
          count_base = '0;
        end
        count_d = count_base;
        if (cur_q.writable) begin
          snap_we  = 1'b1;
          new_mark = 1'b0;
          cand_d   = 1'b1;
          if (count_base != mvcf_pkg::COUNT_MAX) begin
            count_d = count_base + 1'b1;
          end
        end else begin
          new_mark = 1'b1;
        end
      end else if (!excl) begin
        if (keep) begin
          snap_we = (cur_q.op != mvcf_pkg::OP_EQUAL);
          cand_d  = 1'b1;
        end else begin
          exec_mark_we = 1'b1;
          new_mark     = 1'b1;
          drop_d       = 1'b1;
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end
        end
      end
    end
    mark_new                = mark_rdata;
    mark_new[cur_q.bit_sel] = new_mark;
  end

  assign out_valid_d = exec_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_comb begin
    if (sweeping_o) begin
      mark_we    = 1'b1;
      mark_waddr = sweep_q;
      mark_wdata = '1;
    end else begin
      mark_we    = exec_fire && exec_mark_we;
      mark_waddr = cur_q.row_addr;
      mark_wdata = mark_new;
    end
  end

  mvcf_ram #(
    .WIDTH (mvcf_pkg::BYTE_W),
    .DEPTH (mvcf_pkg::STORE_DEPTH)
  ) u_snap_ram (
    .clk_i   (clk_i),
    .we_i    (exec_fire && snap_we),
    .waddr_i (cur_q.snap_addr),
    .wdata_i (cur_q.mem_byte),
    .re_i    (pop_o),
    .raddr_i (head_i.snap_addr),
    .rdata_o (snap_rdata)
  );

  mvcf_ram #(
    .WIDTH (mvcf_pkg::MARK_ROW_W),
    .DEPTH (mvcf_pkg::MARK_ROWS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (pop_o),
    .raddr_i (head_i.row_addr),
    .rdata_o (mark_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mvcf_pkg::BK_SWEEP;
      sweep_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
      if (exec_fire) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (exec_fire) begin
      cand_q <= cand_d;
      drop_q <= drop_d;
    end
  end

  // count only moves when a result is loaded, so it doubles as the result field
  assign out_o.valid           = out_valid_q;
  assign out_o.is_candidate    = cand_q;
  assign out_o.dropped         = drop_q;
  assign out_o.candidate_count = count_q;

  a_no_pop_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mvcf_pkg::BK_SWEEP) |-> !pop_o) else $error("pop during sweep");
  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == mvcf_pkg::BK_EXEC)) else $error("pop not followed by exec");
  a_cand_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(cand_q && drop_q)) else $error("candidate and dropped together");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(count_q)) else $error("count moved in stall");

endmodule
